// ===== hdl/multitap_keypad_text_entry_assert.svh =====
// Assertion macros for the multi-tap keypad text entry block.
// Included by modules that check their own logic; no other dependencies.
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_ASSERT_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MKTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mkte assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MKTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mkte assertion failed");

`endif

// ===== hdl/mkte_pkg.sv =====
// Shared types, codes and character tables of the multi-tap keypad block.
// No dependencies.
`timescale 1ns / 1ps
package mkte_pkg;

  localparam int unsigned KEY_COUNT   = 10;
  localparam int unsigned KEY_W       = $clog2(KEY_COUNT);
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned STR_LEN_MAX = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

  // Grid positions of the helper keys
  localparam logic [3:0] POS_DELETE = 4'd3;
  localparam logic [3:0] POS_READY  = 4'd7;
  localparam logic [3:0] POS_CANCEL = 4'd11;
  localparam logic [3:0] POS_CASE   = 4'd12;
  localparam logic [3:0] POS_SPACE  = 4'd14;
  localparam logic [3:0] POS_DIGITS = 4'd15;
  localparam logic [1:0] ROW_LAST   = 2'd3;
  localparam logic [1:0] COL_ZERO   = 2'd1;
  localparam logic [KEY_W-1:0] KEY_ZERO = 4'd9;

  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_NUL    = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE    = 7'h31;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z  = 7'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'h20;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_REPLACE = 3'd2,
    ACT_DELETE  = 3'd3,
    ACT_READY   = 3'd4,
    ACT_CANCEL  = 3'd5,
    ACT_MODE    = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    MODE_LOWER  = 2'd0,
    MODE_UPPER  = 2'd1,
    MODE_DIGITS = 2'd2
  } mode_e;

  localparam logic [1:0] MODE_CODE_UNUSED = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLE_TIMEOUT = 2'd0,
    REG_START_MODE    = 2'd1
  } reg_idx_e;

  // What the front end decided a key press is
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_READY  = 3'd2,
    KIND_CANCEL = 3'd3,
    KIND_CASE   = 3'd4,
    KIND_SPACE  = 3'd5,
    KIND_DIGITS = 3'd6,
    KIND_KEY    = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // Lowercase strings per key; element 0 is the first character
  localparam logic [KEY_COUNT-1:0][STR_LEN_MAX-1:0][CHAR_W-1:0] LETTER_ROM = {
    {7'h00, 7'h00, 7'h00, 7'h00, 7'h00},  // 0 key
    {7'h39, 7'h7A, 7'h79, 7'h78, 7'h77},  // wxyz9
    {7'h00, 7'h38, 7'h76, 7'h75, 7'h74},  // tuv8
    {7'h37, 7'h73, 7'h72, 7'h71, 7'h70},  // pqrs7
    {7'h00, 7'h36, 7'h6F, 7'h6E, 7'h6D},  // mno6
    {7'h00, 7'h35, 7'h6C, 7'h6B, 7'h6A},  // jkl5
    {7'h00, 7'h34, 7'h69, 7'h68, 7'h67},  // ghi4
    {7'h00, 7'h33, 7'h66, 7'h65, 7'h64},  // def3
    {7'h00, 7'h32, 7'h63, 7'h62, 7'h61},  // abc2
    {7'h00, 7'h00, 7'h00, 7'h00, 7'h00}   // 1 key
  };

  localparam logic [KEY_COUNT-1:0][POS_W-1:0] LETTER_LEN_ROM = {
    3'd0, 3'd5, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd0
  };

  // Digit shown by each key in digit mode
  function automatic logic [CHAR_W-1:0] digit_char(logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    if (key == KEY_ZERO) begin
      ch = CHAR_ZERO;
    end else begin
      ch = CHAR_ONE + CHAR_W'(key);
    end
    return ch;
  endfunction

endpackage

// ===== hdl/mkte_front.sv =====
// Front end: decodes a grid position into a command for the back end.
// Depends on mkte_pkg.
`timescale 1ns / 1ps
module mkte_front
  import mkte_pkg::*;
(
  input  logic [3:0]        key_position_i,
  input  logic [TIME_W-1:0] now_ms_i,
  output cmd_t              cmd_o
);

  logic [1:0] row;
  logic [1:0] col;

  assign row = key_position_i[3:2];
  assign col = key_position_i[1:0];

  // Helper keys first, then the digit keys of the 3x3 block and the 0 key
  always_comb begin
    cmd_o.now  = now_ms_i;
    cmd_o.key  = '0;
    cmd_o.kind = KIND_NONE;
    case (key_position_i)
      POS_DELETE: cmd_o.kind = KIND_DELETE;
      POS_READY:  cmd_o.kind = KIND_READY;
      POS_CANCEL: cmd_o.kind = KIND_CANCEL;
      POS_CASE:   cmd_o.kind = KIND_CASE;
      POS_SPACE:  cmd_o.kind = KIND_SPACE;
      POS_DIGITS: cmd_o.kind = KIND_DIGITS;
      default: begin
        if (row != ROW_LAST && col != 2'd3) begin
          cmd_o.kind = KIND_KEY;
          cmd_o.key  = KEY_W'(row) * KEY_W'(3) + KEY_W'(col);
        end else if (row == ROW_LAST && col == COL_ZERO) begin
          cmd_o.kind = KIND_KEY;
          cmd_o.key  = KEY_ZERO;
        end
      end
    endcase
  end

endmodule

// ===== hdl/mkte_queue.sv =====
// Small command queue between the front end and the back end.
// Depends on mkte_pkg for the command type.
`timescale 1ns / 1ps
module mkte_queue
  import mkte_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/mkte_back.sv =====
// Back end: mode register, per-key cycle state, repeat test and result register.
// Depends on mkte_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "multitap_keypad_text_entry_assert.svh"
module mkte_back
  import mkte_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  cmd_t                  cmd_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output action_e               out_action_o,
  output logic [CHAR_W-1:0]     out_char_o,
  output mode_e                 out_mode_o
);

  mode_e                mode_q, mode_d, press_mode;
  logic [TIMEOUT_W-1:0] timeout_q, timeout_d;
  logic [POS_W-1:0]     cyc_pos_q [KEY_COUNT];
  logic [TIME_W-1:0]    last_time_q [KEY_COUNT];

  logic                 out_valid_q;
  action_e              out_action_q, act;
  logic [CHAR_W-1:0]    out_char_q, ch;
  mode_e                out_mode_q;

  logic                 pop;
  logic                 key_wr;
  logic [KEY_W-1:0]     k;
  logic [POS_W-1:0]     len;
  logic [TIME_W-1:0]    elapsed;
  logic                 repeat_hit;
  logic [POS_W:0]       step;
  logic [POS_W-1:0]     new_pos;

  assign cmd_ready_o  = !out_valid_q || out_ready_i;
  assign pop          = cmd_valid_i && cmd_ready_o;
  assign k            = cmd_i.key;
  assign out_valid_o  = out_valid_q;
  assign out_action_o = out_action_q;
  assign out_char_o   = out_char_q;
  assign out_mode_o   = out_mode_q;

  // Repeat test and next cycle position for a digit key
  always_comb begin
    len        = (mode_q == MODE_DIGITS) ? POS_W'(1) : LETTER_LEN_ROM[k];
    elapsed    = cmd_i.now - last_time_q[k];
    repeat_hit = (elapsed <= TIME_W'(timeout_q));
    step       = {1'b0, cyc_pos_q[k]} + (POS_W + 1)'(1);
    if (!repeat_hit || step >= {1'b0, len}) begin
      new_pos = '0;
    end else begin
      new_pos = step[POS_W-1:0];
    end
  end

  // Execute one command
  always_comb begin
    press_mode = mode_q;
    act        = ACT_NONE;
    ch         = CHAR_NUL;
    key_wr     = 1'b0;
    case (cmd_i.kind)
      KIND_DELETE: act = ACT_DELETE;
      KIND_READY:  act = ACT_READY;
      KIND_CANCEL: act = ACT_CANCEL;
      KIND_CASE: begin
        act        = ACT_MODE;
        press_mode = (mode_q == MODE_LOWER) ? MODE_UPPER : MODE_LOWER;
      end
      KIND_DIGITS: begin
        act        = ACT_MODE;
        press_mode = (mode_q == MODE_DIGITS) ? MODE_LOWER : MODE_DIGITS;
      end
      KIND_SPACE: begin
        act = ACT_INSERT;
        ch  = CHAR_SPACE;
      end
      KIND_KEY: begin
        if (len != '0) begin
          key_wr = 1'b1;
          act    = repeat_hit ? ACT_REPLACE : ACT_INSERT;
          if (mode_q == MODE_DIGITS) begin
            ch = digit_char(k);
          end else begin
            ch = LETTER_ROM[k][new_pos];
            if (mode_q == MODE_UPPER && ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
              ch = ch - CASE_OFFSET;
            end
          end
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  // Mode and timeout: commands and register writes
  always_comb begin
    mode_d    = pop ? press_mode : mode_q;
    timeout_d = timeout_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CYCLE_TIMEOUT: timeout_d = cfg_data_i[TIMEOUT_W-1:0];
        REG_START_MODE: begin
          if (cfg_data_i[1:0] != MODE_CODE_UNUSED) begin
            mode_d = mode_e'(cfg_data_i[1:0]);
          end
        end
        default: timeout_d = timeout_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_LOWER;
      timeout_q   <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < KEY_COUNT; i++) begin
        cyc_pos_q[i]   <= '0;
        last_time_q[i] <= '0;
      end
    end else begin
      mode_q    <= mode_d;
      timeout_q <= timeout_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop && key_wr) begin
        cyc_pos_q[k]   <= new_pos;
        last_time_q[k] <= cmd_i.now;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_action_q <= act;
      out_char_q   <= ch;
      out_mode_q   <= press_mode;
    end
  end

  `MKTE_ASSERT_NEXT(a_pop_loads_result, clk_i, rst_ni, pop, out_valid_q)
  `MKTE_ASSERT_IMP(a_char_only_for_text, clk_i, rst_ni,
    out_valid_q && out_action_q != ACT_INSERT && out_action_q != ACT_REPLACE,
    out_char_q == CHAR_NUL)
  `MKTE_ASSERT_IMP(a_digit_mode_char, clk_i, rst_ni,
    out_valid_q && out_action_q == ACT_REPLACE && out_mode_q == MODE_DIGITS,
    out_char_q >= CHAR_ZERO && out_char_q <= CHAR_NINE)
  `MKTE_ASSERT_IMP(a_mode_code_used, clk_i, rst_ni, 1'b1,
    mode_q != mode_e'(MODE_CODE_UNUSED))

endmodule

// ===== hdl/multitap_keypad_text_entry.sv =====
// An accepted key press passes the queue and the back end's result register to the master side.
// Throughput: one key press per cycle while the master side accepts results, set by the
// back end's read-modify-write of the pressed key's cycle entry; a 2-entry queue decouples the sides.
// Reset (rst_ni, async, active low): mode lowercase, timeout 1000 ms, all key entries
// zero, queue and result register empty. Config writes are always ready.
`timescale 1ns / 1ps
module multitap_keypad_text_entry
  import mkte_pkg::*;
#(
  parameter int unsigned QUEUE_ENTRIES = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: key_position [3:0], now_ms [35:4], zero [39:36]
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [39:0]           s_axis_tdata_i,
  // tdata: action [2:0], char_code [9:3], current_mode [11:10], zero [15:12]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [15:0]           m_axis_tdata_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t              front_cmd;
  cmd_t              queue_cmd;
  logic              queue_valid;
  logic              back_ready;
  action_e           out_action;
  logic [CHAR_W-1:0] out_char;
  mode_e             out_mode;

  assign cfg_ready_o = 1'b1;

  mkte_front u_front (
    .key_position_i (s_axis_tdata_i[3:0]),
    .now_ms_i       (s_axis_tdata_i[35:4]),
    .cmd_o          (front_cmd)
  );

  mkte_queue #(
    .DEPTH (QUEUE_ENTRIES)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid_i),
    .push_ready_o (s_axis_tready_o),
    .push_data_i  (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_cmd)
  );

  mkte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (queue_valid),
    .cmd_ready_o  (back_ready),
    .cmd_i        (queue_cmd),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_action_o (out_action),
    .out_char_o   (out_char),
    .out_mode_o   (out_mode)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata_o = {4'b0000, out_mode, out_char, out_action};

endmodule
